[rtl/tqps_pkg.sv]
// Shared types and constants of the textured quad pixel shader.
// No dependencies; imported by the top level.
`default_nettype none

package tqps_pkg;

    // One command: a texel write or a pixel to shade.
    typedef struct packed {
        logic        action;
        logic [13:0] texel_index;
        logic [31:0] texel_value;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] dest_color;
    } t_cmd;

    // One shaded result.
    typedef struct packed {
        logic [31:0] out_color;
        logic        covered;
    } t_result;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_U_AXIS_X     = 3'd2,
        CFG_U_AXIS_Y     = 3'd3,
        CFG_V_AXIS_X     = 3'd4,
        CFG_V_AXIS_Y     = 3'd5,
        CFG_TINT_COLOR   = 3'd6,
        CFG_TEXTURE_SIZE = 3'd7
    } t_cfg_reg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SHADE = 1'b1;

    localparam logic [31:0] TINT_RESET = 32'hFFFF_FFFF;
    localparam logic [15:0] SIZE_RESET = 16'h8080;

    // 65025 << 24 and 255 << 24
    localparam logic [39:0] LIN_MAX = 40'd65025 << 24;
    localparam logic [32:0] A_ONE   = 33'd255 << 24;

endpackage

`default_nettype wire

[rtl/tqps_div255.sv]
// Pipelined exact floor division by 255 (four register stages).
// Standalone; multiplies by (2^64-1)/255 with shifts, then corrects once.
`default_nettype none

module tqps_div255 #(
    parameter int W = 40
) (
    input  wire logic            i_clk,
    input  wire logic [W-1:0]    i_x,
    output logic      [W-8:0]    o_q
);

    localparam int QW = W - 7;

    logic [W+8:0]  r_y1;
    logic [W+24:0] r_y2;
    logic [QW-1:0] r_q0;
    logic [9:0]    r_x1;
    logic [9:0]    r_x2;
    logic [9:0]    r_x3;

    logic [W+8:0]  y1;
    logic [W+24:0] y2;
    logic [W+56:0] y3;
    logic [9:0]    rem;
    logic [9:0]    q255;

    always_comb begin
        y1   = {9'b0, i_x} + {1'b0, i_x, 8'b0};
        y2   = {16'b0, r_y1} + {r_y1, 16'b0};
        y3   = {32'b0, r_y2} + {r_y2, 32'b0};
        // remainder stays below 510, so ten low bits carry it exactly
        q255 = {r_q0[1:0], 8'b0} - r_q0[9:0];
        rem  = r_x3 - q255;
    end

    always_ff @(posedge i_clk) begin
        r_y1 <= y1;
        r_x1 <= i_x[9:0];
        r_y2 <= y2;
        r_x2 <= r_x1;
        r_q0 <= y3[W+56:64];
        r_x3 <= r_x2;
        o_q  <= r_q0 + QW'(rem >= 10'd255);
    end

endmodule

`default_nettype wire

[rtl/tqps_isqrt.sv]
// Pipelined exact integer square root, one root bit per register stage.
// Standalone.
`default_nettype none

module tqps_isqrt #(
    parameter int N = 21
) (
    input  wire logic             i_clk,
    input  wire logic [2*N-1:0]   i_x,
    output logic      [N-1:0]     o_root
);

    localparam int RW = N + 2;

    logic [2*N-1:0] r_x    [N];
    logic [RW-1:0]  r_rem  [N];
    logic [N-1:0]   r_root [N];
    logic [2*N-1:0] n_x    [N];
    logic [RW-1:0]  n_rem  [N];
    logic [N-1:0]   n_root [N];

    always_comb begin
        logic [2*N-1:0] px;
        logic [RW-1:0]  prem;
        logic [N-1:0]   proot;
        logic [RW-1:0]  rin;
        logic [RW-1:0]  trial;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                px    = i_x;
                prem  = '0;
                proot = '0;
            end else begin
                px    = r_x[k-1];
                prem  = r_rem[k-1];
                proot = r_root[k-1];
            end
            rin   = {prem[RW-3:0], px[2*N-1-2*k -: 2]};
            trial = {proot, 2'b01};
            n_x[k] = px;
            if (rin >= trial) begin
                n_rem[k]  = rin - trial;
                n_root[k] = {proot[N-2:0], 1'b1};
            end else begin
                n_rem[k]  = rin;
                n_root[k] = {proot[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            r_x[k]    <= n_x[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[N-1];

endmodule

`default_nettype wire

[rtl/textured_quad_pixel_shader.sv]
// Top level of the textured quad pixel shader: 43-stage shading pipeline.
// Depends on tqps_pkg, tqps_div255 and tqps_isqrt.
//
//  channel   ports                                  direction  transfer when
//  command   start, busy, i_cmd                     in         start & !busy
//  result    o_strobe, o_result                     out        o_strobe (one cycle)
//  config    i_cfg_we, i_cfg_idx, i_cfg_data        in         i_cfg_we
//
// A command enters every cycle; busy is always low. A shaded pixel leaves
// at the end of the pipeline, whose depth comes chiefly from 21 root stages of
// the square root, two chained divide-by-255 units and the texel memory read.
// A texel write lands in the store at stage 6, in order with the pixel reads.
// Synchronous active-low reset clears the valid bits and the configuration;
// the texel store has no reset. The receiver cannot stall, so nothing holds.
`default_nettype none

module textured_quad_pixel_shader #(
    parameter int TEX_DIM_MAX = 128,
    parameter int COORD_BITS  = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tqps_pkg::t_cmd     i_cmd,
    output logic                    o_strobe,
    output tqps_pkg::t_result       o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import tqps_pkg::*;

    localparam int DEPTH = TEX_DIM_MAX * TEX_DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(TEX_DIM_MAX);
    localparam int DXW   = ((COORD_BITS + 9 > 22) ? COORD_BITS + 9 : 22) + 1;
    localparam int PW    = DXW + 18;
    localparam int UW    = DXW + 19;
    localparam int TXW   = 26 + DW;
    localparam int SQ_N  = 21;
    localparam int LAST  = 42;
    localparam logic [AW-1:0] DIM_A = AW'(TEX_DIM_MAX);
    localparam logic signed [UW-1:0] U_ONE = {{(UW-25){1'b0}}, 1'b1, 24'b0};

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [21:0] r_origin_x;
    logic signed [21:0] r_origin_y;
    logic signed [17:0] r_u_axis_x;
    logic signed [17:0] r_u_axis_y;
    logic signed [17:0] r_v_axis_x;
    logic signed [17:0] r_v_axis_y;
    logic        [31:0] r_tint;
    logic        [15:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_u_axis_x <= '0;
            r_u_axis_y <= '0;
            r_v_axis_x <= '0;
            r_v_axis_y <= '0;
            r_tint     <= TINT_RESET;
            r_size     <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_ORIGIN_X:     r_origin_x <= i_cfg_data[21:0];
                CFG_ORIGIN_Y:     r_origin_y <= i_cfg_data[21:0];
                CFG_U_AXIS_X:     r_u_axis_x <= i_cfg_data[17:0];
                CFG_U_AXIS_Y:     r_u_axis_y <= i_cfg_data[17:0];
                CFG_V_AXIS_X:     r_v_axis_x <= i_cfg_data[17:0];
                CFG_V_AXIS_Y:     r_v_axis_y <= i_cfg_data[17:0];
                CFG_TINT_COLOR:   r_tint     <= i_cfg_data;
                CFG_TEXTURE_SIZE: r_size     <= i_cfg_data[15:0];
                default:          r_size     <= r_size;
            endcase
        end
    end

    // Derived constants, registered: texture span minus two and the
    // premultiplied tint per color channel.
    logic [DW-1:0] r_wm2;
    logic [DW-1:0] r_hm2;
    logic [DW-1:0] n_wm2;
    logic [DW-1:0] n_hm2;
    logic [15:0]   r_tint_mul [3];

    function automatic logic [DW-1:0] span_m2(input logic [7:0] d);
        logic [8:0] c;
        c = {1'b0, d};
        if (c < 9'd2) c = 9'd2;
        if (c > 9'(TEX_DIM_MAX)) c = 9'(TEX_DIM_MAX);
        return DW'(c - 9'd2);
    endfunction

    always_comb begin
        n_wm2 = span_m2(r_size[7:0]);
        n_hm2 = span_m2(r_size[15:8]);
    end

    always_ff @(posedge i_clk) begin
        r_wm2 <= n_wm2;
        r_hm2 <= n_hm2;
        for (int c = 0; c < 3; c++) begin
            r_tint_mul[c] <= 16'(r_tint[8*c +: 8]) * 16'(r_tint[31:24]);
        end
    end

    // ---------------------------------------------------------------
    // item tags: valid shade, coverage, destination color
    // ---------------------------------------------------------------
    logic        r_vld  [1:LAST];
    logic        r_cov  [3:LAST];
    logic [31:0] r_dest [1:LAST];

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // texel write path, stages 1 to 5
    logic          r_we [1:5];
    logic [AW-1:0] r_wa [1:5];
    logic [31:0]   r_wd [1:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAST; s++) r_vld[s] <= 1'b0;
            for (int s = 1; s <= 5; s++) r_we[s] <= 1'b0;
        end else begin
            r_vld[1] <= accept & (i_cmd.action == ACT_SHADE);
            for (int s = 2; s <= LAST; s++) r_vld[s] <= r_vld[s-1];
            r_we[1] <= accept & (i_cmd.action == ACT_WRITE)
                       & (32'(i_cmd.texel_index) < DEPTH);
            for (int s = 2; s <= 5; s++) r_we[s] <= r_we[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dest[1] <= i_cmd.dest_color;
        for (int s = 2; s <= LAST; s++) r_dest[s] <= r_dest[s-1];
        r_wa[1] <= AW'(i_cmd.texel_index);
        r_wd[1] <= i_cmd.texel_value;
        for (int s = 2; s <= 5; s++) begin
            r_wa[s] <= r_wa[s-1];
            r_wd[s] <= r_wd[s-1];
        end
    end

    // ---------------------------------------------------------------
    // stage 1: offset from the origin, Q.8
    // ---------------------------------------------------------------
    logic [15:0]           px_w;
    logic [15:0]           py_w;
    logic signed [DXW-1:0] px_s;
    logic signed [DXW-1:0] py_s;
    logic signed [DXW-1:0] r1_dx;
    logic signed [DXW-1:0] r1_dy;

    always_comb begin
        px_w = 16'(i_cmd.pixel_x);
        py_w = 16'(i_cmd.pixel_y);
        px_s = DXW'($signed({1'b0, px_w[COORD_BITS-1:0], 8'b0}));
        py_s = DXW'($signed({1'b0, py_w[COORD_BITS-1:0], 8'b0}));
    end

    always_ff @(posedge i_clk) begin
        r1_dx <= px_s - DXW'(r_origin_x);
        r1_dy <= py_s - DXW'(r_origin_y);
    end

    // stage 2: the four axis products
    logic signed [PW-1:0] r2_pux;
    logic signed [PW-1:0] r2_puy;
    logic signed [PW-1:0] r2_pvx;
    logic signed [PW-1:0] r2_pvy;

    always_ff @(posedge i_clk) begin
        r2_pux <= PW'(r1_dx) * PW'(r_u_axis_x);
        r2_puy <= PW'(r1_dy) * PW'(r_u_axis_y);
        r2_pvx <= PW'(r1_dx) * PW'(r_v_axis_x);
        r2_pvy <= PW'(r1_dy) * PW'(r_v_axis_y);
    end

    // stage 3: U,V in Q.24, coverage test and clamp to the unit range
    logic signed [UW-1:0] s3_u;
    logic signed [UW-1:0] s3_v;
    logic [24:0]          r3_uc;
    logic [24:0]          r3_vc;

    function automatic logic [24:0] clamp_unit(input logic signed [UW-1:0] a);
        if (a < 0) return 25'd0;
        if (a > U_ONE) return 25'h100_0000;
        return a[24:0];
    endfunction

    always_comb begin
        s3_u = UW'(r2_pux) + UW'(r2_puy);
        s3_v = UW'(r2_pvx) + UW'(r2_pvy);
    end

    // the coverage flag is born here and advances with the pixel
    always_ff @(posedge i_clk) begin
        r_cov[3] <= (s3_u >= 0) && (s3_u <= U_ONE) && (s3_v >= 0) && (s3_v <= U_ONE);
        for (int s = 4; s <= LAST; s++) r_cov[s] <= r_cov[s-1];
        r3_uc    <= clamp_unit(s3_u);
        r3_vc    <= clamp_unit(s3_v);
    end

    // stage 4: texel position, integer part and Q.12 fraction
    logic [TXW-1:0] s4_tx;
    logic [TXW-1:0] s4_ty;
    logic [DW-1:0]  r4_col;
    logic [DW-1:0]  r4_row;
    logic [11:0]    r4_fx;
    logic [11:0]    r4_fy;

    always_comb begin
        s4_tx = TXW'(r3_uc) * TXW'(r_wm2) + TXW'(24'h80_0000);
        s4_ty = TXW'(r3_vc) * TXW'(r_hm2) + TXW'(24'h80_0000);
    end

    always_ff @(posedge i_clk) begin
        r4_col <= s4_tx[24 +: DW];
        r4_row <= s4_ty[24 +: DW];
        r4_fx  <= s4_tx[23:12];
        r4_fy  <= s4_ty[23:12];
    end

    // stage 5: four read addresses and four bilinear weights
    logic [AW-1:0] s5_r0;
    logic [AW-1:0] s5_r1;
    logic [12:0]   s5_fx;
    logic [12:0]   s5_fy;
    logic [12:0]   s5_gx;
    logic [12:0]   s5_gy;
    logic [AW-1:0] r5_a  [4];
    logic [24:0]   r5_wt [4];

    always_comb begin
        s5_r0 = AW'(r4_row) * DIM_A + AW'(r4_col);
        s5_r1 = (AW'(r4_row) + AW'(1)) * DIM_A + AW'(r4_col);
        s5_fx = {1'b0, r4_fx};
        s5_fy = {1'b0, r4_fy};
        s5_gx = 13'h1000 - s5_fx;
        s5_gy = 13'h1000 - s5_fy;
    end

    always_ff @(posedge i_clk) begin
        r5_a[0]  <= s5_r0;
        r5_a[1]  <= s5_r0 + AW'(1);
        r5_a[2]  <= s5_r1;
        r5_a[3]  <= s5_r1 + AW'(1);
        r5_wt[0] <= 25'(26'(s5_gx) * 26'(s5_gy));
        r5_wt[1] <= 25'(26'(s5_fx) * 26'(s5_gy));
        r5_wt[2] <= 25'(26'(s5_gx) * 26'(s5_fy));
        r5_wt[3] <= 25'(26'(s5_fx) * 26'(s5_fy));
    end

    // stage 6: texel store, one copy per corner so each reads one address
    logic [31:0] r_mem [4][DEPTH];
    logic [31:0] r6_tex [4];
    logic [24:0] r6_wt  [4];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (r_we[5]) r_mem[k][r_wa[5]] <= r_wd[5];
            r6_tex[k] <= r_mem[k][r5_a[k]];
            r6_wt[k]  <= r5_wt[k];
        end
    end

    // stage 7: square the color channels
    logic [15:0] r7_c2 [4][3];
    logic [7:0]  r7_a  [4];
    logic [24:0] r7_wt [4];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
                r7_c2[k][c] <= 16'(r6_tex[k][8*c +: 8]) * 16'(r6_tex[k][8*c +: 8]);
            end
            r7_a[k]  <= r6_tex[k][31:24];
            r7_wt[k] <= r6_wt[k];
        end
    end

    // stage 8: weighted corners
    logic [39:0] r8_p  [4][3];
    logic [31:0] r8_pa [4];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
                r8_p[k][c] <= 40'(41'(r7_wt[k]) * 41'(r7_c2[k][c]));
            end
            r8_pa[k] <= 32'(33'(r7_wt[k]) * 33'(r7_a[k]));
        end
    end

    // stage 9: channel sums, Q.24
    logic [39:0] r9_s [3];
    logic [31:0] r9_sa;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r9_s[c] <= 40'(42'(r8_p[0][c]) + 42'(r8_p[1][c])
                         + 42'(r8_p[2][c]) + 42'(r8_p[3][c]));
        end
        r9_sa <= 32'(34'(r8_pa[0]) + 34'(r8_pa[1]) + 34'(r8_pa[2]) + 34'(r8_pa[3]));
    end

    // stage 10: tint products ahead of the divides
    logic [55:0] r10_xc [3];
    logic [39:0] r10_xa;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r10_xc[c] <= 56'(r9_s[c]) * 56'(r_tint_mul[c]);
        end
        r10_xa <= 40'(r9_sa) * 40'(r_tint[31:24]);
    end

    // stages 11..18: tinted alpha (one divide), tinted color (two divides)
    logic [32:0] ta_q;
    logic [48:0] tc1_q [3];
    logic [41:0] tc2_q [3];

    tqps_div255 #(.W(40)) u_div_ta (
        .i_clk (i_clk),
        .i_x   (r10_xa),
        .o_q   (ta_q)
    );

    for (genvar c = 0; c < 3; c++) begin : g_tint
        tqps_div255 #(.W(56)) u_div_c1 (
            .i_clk (i_clk),
            .i_x   (r10_xc[c]),
            .o_q   (tc1_q[c])
        );
        tqps_div255 #(.W(49)) u_div_c2 (
            .i_clk (i_clk),
            .i_x   (tc1_q[c]),
            .o_q   (tc2_q[c])
        );
    end

    // stage 15: inverse alpha and squared destination
    logic [31:0] r15_inv;
    logic [15:0] r15_dd [3];
    logic [7:0]  r15_da;
    logic [32:0] r_ta_d [15:20];
    logic [41:0] r_t_d  [19:20][3];

    always_ff @(posedge i_clk) begin
        r15_inv <= 32'(A_ONE - ta_q);
        for (int c = 0; c < 3; c++) begin
            r15_dd[c] <= 16'(r_dest[14][8*c +: 8]) * 16'(r_dest[14][8*c +: 8]);
        end
        r15_da <= r_dest[14][31:24];
        r_ta_d[15] <= ta_q;
        for (int s = 16; s <= 20; s++) r_ta_d[s] <= r_ta_d[s-1];
        for (int c = 0; c < 3; c++) begin
            r_t_d[19][c] <= tc2_q[c];
            r_t_d[20][c] <= r_t_d[19][c];
        end
    end

    // stage 16: destination weighted by inverse alpha
    logic [47:0] r16_ddinv [3];
    logic [39:0] r16_dainv;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r16_ddinv[c] <= 48'(r15_dd[c]) * 48'(r15_inv);
        end
        r16_dainv <= 40'(r15_da) * 40'(r15_inv);
    end

    // stages 17..20: divide the destination terms
    logic [40:0] ddq [3];
    logic [32:0] daq;

    for (genvar c = 0; c < 3; c++) begin : g_dest
        tqps_div255 #(.W(48)) u_div_dd (
            .i_clk (i_clk),
            .i_x   (r16_ddinv[c]),
            .o_q   (ddq[c])
        );
    end

    tqps_div255 #(.W(40)) u_div_da (
        .i_clk (i_clk),
        .i_x   (r16_dainv),
        .o_q   (daq)
    );

    // stage 21: blend and saturate; finish alpha
    logic [39:0] s21_t [3];
    logic [41:0] s21_b [3];
    logic [33:0] s21_a;
    logic [9:0]  s21_ar;
    logic [39:0] r21_b [3];
    logic [7:0]  r21_alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s21_t[c] = (r_t_d[20][c] > 42'(LIN_MAX)) ? LIN_MAX : r_t_d[20][c][39:0];
            s21_b[c] = 42'(s21_t[c]) + 42'(ddq[c]);
        end
        s21_a  = 34'(r_ta_d[20]) + 34'(daq) + 34'(24'h80_0000);
        s21_ar = s21_a[33:24];
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r21_b[c] <= (s21_b[c] > 42'(LIN_MAX)) ? LIN_MAX : s21_b[c][39:0];
        end
        r21_alpha <= (s21_ar > 10'd255) ? 8'd255 : s21_ar[7:0];
    end

    // stages 22..42: square roots; hold alpha alongside
    logic [SQ_N-1:0] root [3];
    logic [7:0]      r_ad [22:LAST];

    for (genvar c = 0; c < 3; c++) begin : g_root
        tqps_isqrt #(.N(SQ_N)) u_isqrt (
            .i_clk  (i_clk),
            .i_x    ({r21_b[c], 2'b00}),
            .o_root (root[c])
        );
    end

    always_ff @(posedge i_clk) begin
        r_ad[22] <= r21_alpha;
        for (int s = 23; s <= LAST; s++) r_ad[s] <= r_ad[s-1];
    end

    // stage 43: round, saturate and drive the result
    logic [SQ_N:0] s43_r  [3];
    logic [8:0]    s43_hi [3];
    logic [7:0]    s43_ch [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s43_r[c]  = (SQ_N+1)'(root[c]) + (SQ_N+1)'(13'h1000);
            s43_hi[c] = s43_r[c][21:13];
            s43_ch[c] = (s43_hi[c] > 9'd255) ? 8'd255 : s43_hi[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        // uncovered pixels pass the destination through
        o_result.covered   <= r_cov[LAST];
        o_result.out_color <= r_cov[LAST]
                              ? {r_ad[LAST], s43_ch[2], s43_ch[1], s43_ch[0]}
                              : r_dest[LAST];
    end

endmodule

`default_nettype wire
